// ===== src/rmcf_pkg.sv =====
package rmcf_pkg;

    // Command value range and the widths that follow from it
    localparam int SPEED_LIMIT = 250;
    localparam int VAL_W       = $clog2(SPEED_LIMIT + 1) + 1;
    localparam int MAG_W       = VAL_W - 1;
    localparam int ARITH_W     = (VAL_W >= 9) ? VAL_W + 1 : 10;

    localparam int BYTE_W     = 8;
    localparam int STEP_W     = 8;
    localparam int INTERVAL_W = 16;
    localparam int TICK_W     = 17;
    localparam int IN_W       = 16;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [BYTE_W-1:0] ACTIVATE_BYTE = 8'hAA;
    localparam logic [BYTE_W-1:0] CKSUM_MASK = 8'h7F;
    localparam logic [BYTE_W-1:0] CMD_FWD    = 8'd8;
    localparam logic [BYTE_W-1:0] CMD_BCK    = 8'd9;
    localparam logic [BYTE_W-1:0] CMD_RIGHT  = 8'd10;
    localparam logic [BYTE_W-1:0] CMD_LEFT   = 8'd11;

    localparam logic [BYTE_W-1:0]     DEV_ADDR_RST      = 8'd128;
    localparam logic [STEP_W-1:0]     SPEED_STEP_RST    = 8'd40;
    localparam logic [STEP_W-1:0]     TURN_STEP_RST     = 8'd40;
    localparam logic [INTERVAL_W-1:0] TICK_INTERVAL_RST = 16'd20;

    // Byte index of the last byte of a two-packet frame
    localparam logic [2:0] LAST_IDX = 3'd7;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_SET_TARGET,
        OP_STOP,
        OP_ACTIVATE
    } t_opcode;

    typedef enum logic [1:0] {
        REG_DEV_ADDR,
        REG_SPEED_STEP,
        REG_TURN_STEP,
        REG_TICK_INTERVAL
    } t_reg_idx;

    typedef enum logic [1:0] {
        POS_ADDR,
        POS_CMD,
        POS_DATA,
        POS_CKSUM
    } t_pkt_pos;

    typedef struct packed {
        logic [BYTE_W-1:0]     dev_addr;
        logic [STEP_W-1:0]     speed_step;
        logic [STEP_W-1:0]     turn_step;
        logic [INTERVAL_W-1:0] tick_interval;
    } t_cfg;

    typedef struct packed {
        logic              is_start;
        logic [BYTE_W-1:0] spd_cmd;
        logic [MAG_W-1:0]  spd_mag;
        logic [BYTE_W-1:0] trn_cmd;
        logic [MAG_W-1:0]  trn_mag;
    } t_cmd_entry;

    typedef logic [SPEED_LIMIT:0][BYTE_W-1:0] t_curve_rom;

    // Fixed-point constants of the curve (Q32)
    localparam logic [63:0] ONE_Q32      = 64'h0000_0001_0000_0000;
    localparam logic [63:0] LN2_Q32      = 64'd2977044472;
    localparam logic [63:0] NINE_Q32     = 64'd9 << 32;
    localparam logic [63:0] ROUND_Q16    = 64'd9 << 16;
    localparam logic [63:0] CURVE_MAX    = 64'd500;
    localparam logic [63:0] DATA_SCALE   = 64'd127;
    localparam logic [63:0] CURVE_DIV    = 64'd9;
    localparam logic [63:0] SPEED_CURVE_C = 64'd2;
    localparam logic [63:0] TURN_CURVE_C  = 64'd3;

    // Shift-subtract divide, used only while building the curve tables
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // ln(p) in Q32 via atanh series
    function automatic logic [63:0] ln_q32(input logic [31:0] p);
        logic [31:0] k;
        logic [63:0] m;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] term;
        logic [63:0] acc;
        k   = '0;
        acc = '0;
        while (k < 32'd31 && (p >> (k + 32'd1)) != 32'd0) k = k + 32'd1;
        m    = ({32'b0, p} << 32) >> k;
        z    = udiv64((m - ONE_Q32) << 32, m + ONE_Q32);
        z2   = (z * z) >> 32;
        term = z;
        for (int i = 0; i < 24; i++) begin
            acc  = acc + udiv64(term, 64'(2 * i + 1));
            term = (term * z2) >> 32;
        end
        return {32'b0, k} * LN2_Q32 + 64'd2 * acc;
    endfunction

    // exp(y) in Q32 via range reduction and Taylor series
    function automatic logic [63:0] exp_q32(input logic [63:0] y);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] sum;
        logic [63:0] term;
        n    = udiv64(y, LN2_Q32);
        r    = y - n * LN2_Q32;
        sum  = ONE_Q32;
        term = ONE_Q32;
        for (int i = 1; i <= 24; i++) begin
            term = udiv64((term * r) >> 32, 64'(i));
            sum  = sum + term;
        end
        if (n > 64'd20) n = 64'd20;
        return sum << n;
    endfunction

    // Packet data byte for magnitude p and curve constant c
    function automatic logic [BYTE_W-1:0] curve_data(input logic [31:0] p_in,
                                                     input logic [63:0] c);
        logic [31:0] p;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] lv;
        logic [63:0] scaled;
        p = p_in;
        if (p == 32'd0) return '0;
        if ({32'b0, p} > CURVE_MAX) p = CURVE_MAX[31:0];
        e      = exp_q32((ln_q32(p) * {32'b0, p}) / CURVE_MAX);
        num    = (({32'b0, p} * c) << 32) + e * (CURVE_DIV - c) + ROUND_Q16;
        lv     = num / NINE_Q32;
        scaled = (lv * DATA_SCALE) / CURVE_MAX;
        return scaled[BYTE_W-1:0];
    endfunction

    function automatic t_curve_rom build_rom(input logic [63:0] c);
        t_curve_rom rom;
        for (int p = 0; p <= SPEED_LIMIT; p++) begin
            rom[p] = curve_data(32'(p), c);
        end
        return rom;
    endfunction

    localparam t_curve_rom SPEED_ROM = build_rom(SPEED_CURVE_C);
    localparam t_curve_rom TURN_ROM  = build_rom(TURN_CURVE_C);

    // Clamp a raw 16-bit request to +-SPEED_LIMIT
    function automatic logic signed [VAL_W-1:0] clamp_target(input logic signed [IN_W-1:0] x);
        logic signed [IN_W-1:0] lim;
        lim = IN_W'(SPEED_LIMIT);
        if (x > lim) return VAL_W'(SPEED_LIMIT);
        if (x < -lim) return -VAL_W'(SPEED_LIMIT);
        return VAL_W'(x);
    endfunction

    function automatic logic [MAG_W-1:0] abs_mag(input logic signed [VAL_W-1:0] v);
        logic signed [VAL_W-1:0] a;
        a = (v < 0) ? -v : v;
        return a[MAG_W-1:0];
    endfunction

endpackage

// ===== src/ramped_motor_command_framer_top.sv =====
// Ramped motor command framer. Items enter through a queue-style port (push/full):
// opcode 0 is a millisecond tick, 1 sets speed and turn targets (clamped to +-250),
// 2 is an emergency stop and 3 activates the driver. Once more ticks than
// tick_interval have gone by, each current value moves toward its target by at
// most its step limit and two 4-byte packets go out on the result side
// (empty/pop): address, command, data, checksum, speed packet first. Stop sends
// forward-0 and left-0 packets; activate sends the single start byte 0xAA. The
// final byte caused by an item carries last_byte. The front end takes one item
// per clock while its 4-deep command queue has room; the byte sequencer behind it
// sends one byte per clock while bytes are popped, so a processing tick or a stop
// occupies it for 8 bytes, activate for 1; ticks without processing or set-target
// items cost no output time. Each item passes the queue, then the packet and
// output registers. Registers sit on the APB port at 0x0 address, 0x4 speed step,
// 0x8 turn step, 0xC tick interval; change them only while no bytes are pending.
module ramped_motor_command_framer_top
    import rmcf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // item side
    input  logic                   push,
    output logic                   full,
    input  logic [1:0]             i_opcode,
    input  logic signed [IN_W-1:0] i_target_speed,
    input  logic signed [IN_W-1:0] i_target_turn,
    // byte side
    output logic                   empty,
    input  logic                   pop,
    output logic [BYTE_W-1:0]      o_tx_byte,
    output logic                   o_last_byte,
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    t_cfg       cfg;
    logic       accept;
    logic       q_push;
    t_cmd_entry q_in;
    logic       q_valid;
    logic       q_pop;
    t_cmd_entry q_out;

    // Take an item beat only while the command queue has room
    assign accept = push && !full;

    rmcf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Front end: update targets, tick count and ramp; classify into frames
    rmcf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_accept       (accept),
        .i_opcode       (i_opcode),
        .i_target_speed (i_target_speed),
        .i_target_turn  (i_target_turn),
        .o_q_push       (q_push),
        .o_q_entry      (q_in)
    );

    // Decouple classification from byte transmission
    rmcf_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (full),
        .o_entry (q_out)
    );

    // Back end: curve lookup, packet build, one byte beat per clock unless stalled
    rmcf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_out),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_tx_byte   (o_tx_byte),
        .o_last_byte (o_last_byte)
    );

endmodule

// ===== src/rmcf_regs.sv =====
module rmcf_regs
    import rmcf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dev_addr      <= DEV_ADDR_RST;
            r_cfg.speed_step    <= SPEED_STEP_RST;
            r_cfg.turn_step     <= TURN_STEP_RST;
            r_cfg.tick_interval <= TICK_INTERVAL_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_DEV_ADDR:      r_cfg.dev_addr      <= pwdata[BYTE_W-1:0];
                REG_SPEED_STEP:    r_cfg.speed_step    <= pwdata[STEP_W-1:0];
                REG_TURN_STEP:     r_cfg.turn_step     <= pwdata[STEP_W-1:0];
                REG_TICK_INTERVAL: r_cfg.tick_interval <= pwdata[INTERVAL_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DEV_ADDR:      prdata = PDATA_W'(r_cfg.dev_addr);
            REG_SPEED_STEP:    prdata = PDATA_W'(r_cfg.speed_step);
            REG_TURN_STEP:     prdata = PDATA_W'(r_cfg.turn_step);
            REG_TICK_INTERVAL: prdata = PDATA_W'(r_cfg.tick_interval);
        endcase
    end

endmodule

// ===== src/rmcf_front.sv =====
module rmcf_front
    import rmcf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_accept,
    input  logic [1:0]             i_opcode,
    input  logic signed [IN_W-1:0] i_target_speed,
    input  logic signed [IN_W-1:0] i_target_turn,
    output logic                   o_q_push,
    output t_cmd_entry             o_q_entry
);

    logic signed [VAL_W-1:0] r_speed_now,  n_speed_now;
    logic signed [VAL_W-1:0] r_turn_now,   n_turn_now;
    logic signed [VAL_W-1:0] r_speed_goal, n_speed_goal;
    logic signed [VAL_W-1:0] r_turn_goal,  n_turn_goal;
    logic [TICK_W-1:0]       r_elapsed,    n_elapsed;

    logic [TICK_W-1:0]       elapsed_inc;
    logic signed [VAL_W-1:0] speed_step_val;
    logic signed [VAL_W-1:0] turn_step_val;

    // Move one value toward its goal by at most step, then hold within range
    function automatic logic signed [VAL_W-1:0] ramp(input logic signed [VAL_W-1:0] now,
                                                      input logic signed [VAL_W-1:0] goal,
                                                      input logic [STEP_W-1:0] step);
        logic signed [ARITH_W-1:0] diff;
        logic signed [ARITH_W-1:0] lim;
        logic signed [ARITH_W-1:0] delta;
        logic signed [ARITH_W-1:0] sum;
        logic signed [ARITH_W-1:0] range;
        diff  = ARITH_W'(goal) - ARITH_W'(now);
        lim   = $signed(ARITH_W'(step));
        range = ARITH_W'(SPEED_LIMIT);
        if (diff > lim) delta = lim;
        else if (diff < -lim) delta = -lim;
        else delta = diff;
        sum = ARITH_W'(now) + delta;
        if (sum > range) sum = range;
        else if (sum < -range) sum = -range;
        return VAL_W'(sum);
    endfunction

    assign elapsed_inc    = (r_elapsed == TICK_MAX) ? r_elapsed : r_elapsed + TICK_W'(1);
    assign speed_step_val = ramp(r_speed_now, r_speed_goal, i_cfg.speed_step);
    assign turn_step_val  = ramp(r_turn_now, r_turn_goal, i_cfg.turn_step);

    always_comb begin
        n_speed_now  = r_speed_now;
        n_turn_now   = r_turn_now;
        n_speed_goal = r_speed_goal;
        n_turn_goal  = r_turn_goal;
        n_elapsed    = r_elapsed;
        o_q_push     = 1'b0;
        o_q_entry    = '0;
        if (i_accept) begin
            unique case (t_opcode'(i_opcode))
                OP_TICK: begin
                    if (elapsed_inc > TICK_W'(i_cfg.tick_interval)) begin
                        n_elapsed         = '0;
                        n_speed_now       = speed_step_val;
                        n_turn_now        = turn_step_val;
                        o_q_push          = 1'b1;
                        o_q_entry.spd_cmd = (speed_step_val < 0) ? CMD_BCK : CMD_FWD;
                        o_q_entry.spd_mag = abs_mag(speed_step_val);
                        o_q_entry.trn_cmd = (turn_step_val < 0) ? CMD_RIGHT : CMD_LEFT;
                        o_q_entry.trn_mag = abs_mag(turn_step_val);
                    end else begin
                        n_elapsed = elapsed_inc;
                    end
                end
                OP_SET_TARGET: begin
                    n_speed_goal = clamp_target(i_target_speed);
                    n_turn_goal  = clamp_target(i_target_turn);
                end
                OP_STOP: begin
                    n_speed_now       = '0;
                    n_turn_now        = '0;
                    n_speed_goal      = '0;
                    n_turn_goal       = '0;
                    o_q_push          = 1'b1;
                    o_q_entry.spd_cmd = CMD_FWD;
                    o_q_entry.trn_cmd = CMD_LEFT;
                end
                OP_ACTIVATE: begin
                    o_q_push           = 1'b1;
                    o_q_entry.is_start = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_now  <= '0;
            r_turn_now   <= '0;
            r_speed_goal <= '0;
            r_turn_goal  <= '0;
            r_elapsed    <= '0;
        end else begin
            r_speed_now  <= n_speed_now;
            r_turn_now   <= n_turn_now;
            r_speed_goal <= n_speed_goal;
            r_turn_goal  <= n_turn_goal;
            r_elapsed    <= n_elapsed;
        end
    end

endmodule

// ===== src/rmcf_cmd_queue.sv =====
module rmcf_cmd_queue
    import rmcf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_cmd_entry i_entry,
    input  logic       i_pop,
    output logic       o_valid,
    output logic       o_full,
    output t_cmd_entry o_entry
);

    t_cmd_entry        r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            if (do_pop) r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            if (do_push && !do_pop) r_count <= r_count + QCNT_W'(1);
            else if (do_pop && !do_push) r_count <= r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_entry;
    end

endmodule

// ===== src/rmcf_back.sv =====
module rmcf_back
    import rmcf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_q_valid,
    input  t_cmd_entry        i_q_entry,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [BYTE_W-1:0] o_tx_byte,
    output logic              o_last_byte
);

    logic              r_busy;
    logic [2:0]        r_idx;
    logic              r_is_start;
    logic [BYTE_W-1:0] r_spd_cmd;
    logic [BYTE_W-1:0] r_spd_data;
    logic [BYTE_W-1:0] r_trn_cmd;
    logic [BYTE_W-1:0] r_trn_data;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;

    logic              out_free;
    logic              emit;
    logic              item_done;
    logic [BYTE_W-1:0] cur_cmd;
    logic [BYTE_W-1:0] cur_data;
    logic [BYTE_W-1:0] cksum;
    logic [BYTE_W-1:0] next_byte;
    t_pkt_pos          pos;

    assign out_free  = !r_out_valid || i_pop;
    assign emit      = r_busy && out_free;
    assign item_done = emit && (r_is_start || r_idx == LAST_IDX);
    assign o_q_pop   = i_q_valid && (!r_busy || item_done);

    // Upper index bit picks the turn packet
    assign cur_cmd  = r_idx[2] ? r_trn_cmd : r_spd_cmd;
    assign cur_data = r_idx[2] ? r_trn_data : r_spd_data;
    assign cksum    = (i_cfg.dev_addr + cur_cmd + cur_data) & CKSUM_MASK;
    assign pos      = t_pkt_pos'(r_idx[1:0]);

    always_comb begin
        unique case (pos)
            POS_ADDR:  next_byte = i_cfg.dev_addr;
            POS_CMD:   next_byte = cur_cmd;
            POS_DATA:  next_byte = cur_data;
            POS_CKSUM: next_byte = cksum;
        endcase
        if (r_is_start) next_byte = ACTIVATE_BYTE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (item_done) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                r_idx <= r_idx + 3'd1;
            end
            if (emit) r_out_valid <= 1'b1;
            else if (i_pop) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_is_start <= i_q_entry.is_start;
            r_spd_cmd  <= i_q_entry.spd_cmd;
            r_spd_data <= SPEED_ROM[i_q_entry.spd_mag];
            r_trn_cmd  <= i_q_entry.trn_cmd;
            r_trn_data <= TURN_ROM[i_q_entry.trn_mag];
        end
        if (emit) begin
            r_out_byte <= next_byte;
            r_out_last <= r_is_start || r_idx == LAST_IDX;
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_tx_byte   = r_out_byte;
    assign o_last_byte = r_out_last;

endmodule

// ===== src/rmcf_checker.sv =====
module rmcf_checker
    import rmcf_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              push,
    input logic              full,
    input logic              pop,
    input logic              empty,
    input logic [BYTE_W-1:0] o_tx_byte,
    input logic              o_last_byte
);

    // Come out of reset with nothing pending and room for items
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("byte side or queue not cleared by reset");

    // A frame continues without a gap once its first bytes are taken
    a_frame_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last_byte) |=> !empty)
        else $error("gap inside a frame");

    // Queue only fills after an item beat
    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a push");

    // Stalled byte holds
    a_byte_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_tx_byte) && $stable(o_last_byte)))
        else $error("stalled byte changed");

endmodule

bind ramped_motor_command_framer_top rmcf_checker u_checker (.*);
